// ----- src/sccb_pkg.sv -----
// Package for the SCCB register access master: payload structs, bus element
// codes, sequence constants and small helper functions. No dependencies.

package sccb_pkg;

  localparam int unsigned DEV_ADDR_W = 7;
  localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET = 7'd33;

  // Sequence step codes
  localparam logic [5:0] STEP_IDLE  = 6'd0;
  localparam logic [5:0] STEP_FIRST = 6'd1;
  localparam logic [5:0] STEP_ABORT = 6'd63;
  localparam logic [5:0] WRITE_LEN  = 6'd7;
  localparam logic [5:0] READ_LEN   = 6'd12;

  // Tick positions inside a sent byte
  localparam logic [4:0] SEND_BITS_END = 5'd24;
  localparam logic [4:0] SEND_RELEASE  = 5'd25;
  localparam logic [4:0] SEND_ACK      = 5'd26;
  localparam logic [4:0] SEND_LAST     = 5'd27;
  // Last tick of a received byte
  localparam logic [4:0] RECV_LAST     = 5'd24;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NACK_DEV  = 2'd1;
  localparam logic [1:0] STATUS_NACK_REG  = 2'd2;
  localparam logic [1:0] STATUS_NACK_DATA = 2'd3;

  typedef enum logic [3:0] {
    EL_START,
    EL_DEV,
    EL_REG,
    EL_DAT,
    EL_RDDEV,
    EL_GAP,
    EL_STOP,
    EL_RBYTE,
    EL_NACK
  } element_t;

  typedef struct packed {
    logic       start_req;
    logic       kind;
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;
  } res_t;

  // Bus element played at a given step of a write or read sequence
  function automatic element_t prog_elem(input logic is_read, input logic [5:0] step);
    element_t el;
    el = EL_STOP;
    if (is_read) begin
      unique case (step)
        6'd1:    el = EL_START;
        6'd2:    el = EL_DEV;
        6'd3:    el = EL_GAP;
        6'd4:    el = EL_REG;
        6'd5:    el = EL_STOP;
        6'd6:    el = EL_GAP;
        6'd7:    el = EL_START;
        6'd8:    el = EL_RDDEV;
        6'd9:    el = EL_GAP;
        6'd10:   el = EL_RBYTE;
        6'd11:   el = EL_NACK;
        default: el = EL_STOP;
      endcase
    end else begin
      unique case (step)
        6'd1:    el = EL_START;
        6'd2:    el = EL_DEV;
        6'd3:    el = EL_GAP;
        6'd4:    el = EL_REG;
        6'd5:    el = EL_GAP;
        6'd6:    el = EL_DAT;
        default: el = EL_STOP;
      endcase
    end
    return el;
  endfunction

  // Remainder by three of a 5-bit value: quotient by reciprocal 11/32
  function automatic logic [1:0] mod3(input logic [4:0] v);
    logic [8:0] prod;
    logic [4:0] quot;
    logic [4:0] rem;
    prod = {4'b0, v} * 9'd11;
    quot = {1'b0, prod[8:5]};
    rem  = v - 5'(quot * 5'd3);
    return rem[1:0];
  endfunction

endpackage

// ----- src/sccb_in_if.sv -----
// Input channel of the SCCB master: one bus tick with its command fields.
// Depends on nothing.

interface sccb_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic       kind;
  logic [7:0] reg_addr;
  logic [7:0] reg_data;
  logic       sda_in;

  modport source (output valid, start_req, kind, reg_addr, reg_data, sda_in, input ready);
  modport sink (input valid, start_req, kind, reg_addr, reg_data, sda_in, output ready);
endinterface

// ----- src/sccb_out_if.sv -----
// Output channel of the SCCB master: line levels and status of one tick.
// Depends on nothing.

interface sccb_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;
  logic [7:0] read_data;

  modport source (output valid, scl, sda_out, sda_drive, busy_res, done_res, status,
                  read_data, input ready);
  modport sink (input valid, scl, sda_out, sda_drive, busy_res, done_res, status,
                read_data, output ready);
endinterface

// ----- src/sccb_engine.sv -----
// Bus sequencer of the SCCB master: holds the transaction state and works out
// one tick per advance. Depends on sccb_pkg.

module sccb_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  sccb_pkg::cmd_t                cmd,
  input  logic [sccb_pkg::DEV_ADDR_W-1:0] dev_addr,
  output sccb_pkg::res_t                res
);

  logic [5:0] step, step_next;
  logic [4:0] tick, tick_next;
  logic [7:0] shift_byte, shift_next;
  logic       op_is_read, op_next;
  logic [7:0] held_reg, held_reg_next;
  logic [7:0] held_data, held_data_next;
  logic [1:0] status, status_next;
  logic [7:0] rx_byte, rx_next;
  logic       clk_level, clk_level_next;
  logic       dat_level, dat_level_next;

  always_comb begin
    sccb_pkg::element_t el;
    logic       drive;
    logic       busy;
    logic       done;
    logic       last;
    logic       is_send;
    logic [5:0] plen;
    logic [1:0] ph;

    step_next      = step;
    tick_next      = tick;
    shift_next     = shift_byte;
    op_next        = op_is_read;
    held_reg_next  = held_reg;
    held_data_next = held_data;
    status_next    = status;
    rx_next        = rx_byte;
    clk_level_next = clk_level;
    dat_level_next = dat_level;
    drive   = 1'b1;
    busy    = 1'b0;
    done    = 1'b0;
    last    = 1'b0;
    is_send = 1'b0;
    el      = sccb_pkg::EL_GAP;
    plen    = sccb_pkg::WRITE_LEN;
    ph      = 2'd0;

    // Take a command on an idle tick and start on that same tick
    if (step == sccb_pkg::STEP_IDLE && cmd.start_req) begin
      op_next        = cmd.kind;
      held_reg_next  = cmd.reg_addr;
      held_data_next = cmd.reg_data;
      status_next    = sccb_pkg::STATUS_OK;
      step_next      = sccb_pkg::STEP_FIRST;
      tick_next      = 5'd0;
    end

    if (step_next != sccb_pkg::STEP_IDLE) begin
      busy = 1'b1;
      plen = op_next ? sccb_pkg::READ_LEN : sccb_pkg::WRITE_LEN;
      el   = sccb_pkg::prog_elem(op_next, step_next);

      unique case (el) inside
        sccb_pkg::EL_START: begin
          unique case (tick_next)
            5'd0:    dat_level_next = 1'b1;
            5'd1:    clk_level_next = 1'b1;
            5'd2:    dat_level_next = 1'b0;
            default: begin
              clk_level_next = 1'b0;
              last = 1'b1;
            end
          endcase
        end
        sccb_pkg::EL_DEV, sccb_pkg::EL_REG, sccb_pkg::EL_DAT, sccb_pkg::EL_RDDEV: begin
          is_send = 1'b1;
          if (tick_next == 5'd0) begin
            unique case (el) inside
              sccb_pkg::EL_DEV: shift_next = {dev_addr, 1'b0};
              sccb_pkg::EL_REG: shift_next = held_reg_next;
              sccb_pkg::EL_DAT: shift_next = held_data_next;
              default:          shift_next = {dev_addr, 1'b1};
            endcase
          end
          if (tick_next < sccb_pkg::SEND_BITS_END) begin
            ph = sccb_pkg::mod3(tick_next);
            case (ph)
              2'd0:    dat_level_next = shift_next[7];
              2'd1:    clk_level_next = 1'b1;
              default: begin
                clk_level_next = 1'b0;
                shift_next     = {shift_next[6:0], 1'b0};
              end
            endcase
          end else if (tick_next == sccb_pkg::SEND_RELEASE) begin
            drive = 1'b0;
          end else if (tick_next == sccb_pkg::SEND_ACK) begin
            drive          = 1'b0;
            clk_level_next = 1'b1;
            // Line high on the ACK clock: record which byte went unanswered
            if (cmd.sda_in) begin
              unique case (el) inside
                sccb_pkg::EL_DEV: status_next = sccb_pkg::STATUS_NACK_DEV;
                sccb_pkg::EL_REG: status_next = sccb_pkg::STATUS_NACK_REG;
                default:          status_next = sccb_pkg::STATUS_NACK_DATA;
              endcase
            end
          end else if (tick_next >= sccb_pkg::SEND_LAST) begin
            drive          = 1'b0;
            clk_level_next = 1'b0;
            last           = 1'b1;
          end
        end
        sccb_pkg::EL_GAP: last = 1'b1;
        sccb_pkg::EL_STOP: begin
          unique case (tick_next)
            5'd0:    dat_level_next = 1'b0;
            5'd1:    clk_level_next = 1'b1;
            default: begin
              dat_level_next = 1'b1;
              last = 1'b1;
            end
          endcase
        end
        sccb_pkg::EL_RBYTE: begin
          drive = 1'b0;
          if (tick_next == 5'd0) begin
            shift_next = 8'd0;
          end else begin
            ph = sccb_pkg::mod3(tick_next - 5'd1);
            case (ph)
              2'd1: begin
                clk_level_next = 1'b1;
                shift_next     = {shift_next[6:0], cmd.sda_in};
              end
              2'd2:    clk_level_next = 1'b0;
              default: ;
            endcase
            if (tick_next >= sccb_pkg::RECV_LAST) begin
              rx_next = shift_next;
              last    = 1'b1;
            end
          end
        end
        default: begin
          unique case (tick_next)
            5'd0:    dat_level_next = 1'b1;
            5'd1:    clk_level_next = 1'b1;
            5'd2:    clk_level_next = 1'b0;
            default: begin
              dat_level_next = 1'b0;
              last = 1'b1;
            end
          endcase
        end
      endcase

      if (last) begin
        tick_next = 5'd0;
        if (step_next == sccb_pkg::STEP_ABORT || step_next >= plen) begin
          done      = 1'b1;
          step_next = sccb_pkg::STEP_IDLE;
        end else if (is_send && status_next != sccb_pkg::STATUS_OK) begin
          step_next = sccb_pkg::STEP_ABORT;
        end else begin
          step_next = step_next + 6'd1;
        end
      end else begin
        tick_next = tick_next + 5'd1;
      end
    end

    res.scl       = clk_level_next;
    res.sda_out   = dat_level_next;
    res.sda_drive = drive;
    res.busy_res  = busy;
    res.done_res  = done;
    res.status    = status_next;
    res.read_data = rx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= sccb_pkg::STEP_IDLE;
      tick       <= 5'd0;
      op_is_read <= 1'b0;
      status     <= sccb_pkg::STATUS_OK;
      rx_byte    <= 8'd0;
      clk_level  <= 1'b1;
      dat_level  <= 1'b1;
    end else if (adv) begin
      step       <= step_next;
      tick       <= tick_next;
      op_is_read <= op_next;
      status     <= status_next;
      rx_byte    <= rx_next;
      clk_level  <= clk_level_next;
      dat_level  <= dat_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      shift_byte <= shift_next;
      held_reg   <= held_reg_next;
      held_data  <= held_data_next;
    end
  end

  a_done_is_busy: assert property (@(posedge clk) disable iff (rst)
    (adv && res.done_res) |-> res.busy_res)
    else $error("done raised outside a transaction");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (adv && res.done_res) |=> (step == sccb_pkg::STEP_IDLE))
    else $error("sequencer not idle after finishing");

  a_idle_drives: assert property (@(posedge clk) disable iff (rst)
    (adv && step == sccb_pkg::STEP_IDLE && !cmd.start_req) |->
      (res.sda_drive && !res.busy_res && step_next == sccb_pkg::STEP_IDLE))
    else $error("idle tick released the line or reported busy");

  a_tick_range: assert property (@(posedge clk) disable iff (rst)
    tick <= sccb_pkg::SEND_LAST)
    else $error("tick counter ran past the longest element");

  a_idle_tick_zero: assert property (@(posedge clk) disable iff (rst)
    (step == sccb_pkg::STEP_IDLE) |-> (tick == 5'd0))
    else $error("tick counter not cleared while idle");

endmodule

// ----- src/sccb_register_access_master_top.sv -----
// SCCB register access master. Each input transfer is one bus tick: the
// sampled data line plus, on an idle tick, an optional register write or
// read command; each tick yields one output transfer with the clock and data
// line levels, the data drive enable, busy, done, status and the last read
// byte. One tick is taken every clock cycle unless the output stalls; the
// result passes the input register, then the result register, as the whole
// bus sequencer step is worked out combinationally. Output stalls back up
// into the input. The device address is written through cfg_we/cfg_wdata;
// the user must write it only while no transaction runs (not enforced by the
// block). Depends on sccb_pkg, sccb_in_if, sccb_out_if and sccb_engine.

module sccb_register_access_master_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sccb_pkg::DEV_ADDR_W-1:0] cfg_wdata,
  sccb_in_if.sink                         in_ch,
  sccb_out_if.source                      out_ch
);

  logic [sccb_pkg::DEV_ADDR_W-1:0] dev_addr;
  logic           in_valid;
  sccb_pkg::cmd_t in_cmd;
  logic           res_valid;
  sccb_pkg::res_t res_reg;
  sccb_pkg::res_t res_comb;
  logic           adv;

  assign adv         = in_valid && (!res_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || !res_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= sccb_pkg::DEV_ADDR_RESET;
    end else if (cfg_we) begin
      dev_addr <= cfg_wdata;
    end
  end

  // Input register: hold a tick until the sequencer can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_cmd.start_req <= in_ch.start_req;
      in_cmd.kind      <= in_ch.kind;
      in_cmd.reg_addr  <= in_ch.reg_addr;
      in_cmd.reg_data  <= in_ch.reg_data;
      in_cmd.sda_in    <= in_ch.sda_in;
    end
  end

  sccb_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .cmd      (in_cmd),
    .dev_addr (dev_addr),
    .res      (res_comb)
  );

  // Result register: drop the valid once the transfer is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_reg <= res_comb;
    end
  end

  assign out_ch.valid     = res_valid;
  assign out_ch.scl       = res_reg.scl;
  assign out_ch.sda_out   = res_reg.sda_out;
  assign out_ch.sda_drive = res_reg.sda_drive;
  assign out_ch.busy_res  = res_reg.busy_res;
  assign out_ch.done_res  = res_reg.done_res;
  assign out_ch.status    = res_reg.status;
  assign out_ch.read_data = res_reg.read_data;

endmodule
